### rtl/stt_pkg.sv
package stt_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CntW = 16;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;

  typedef enum logic [1:0] {
    EV_WORD_CHAR = 2'd0,
    EV_WORD_END  = 2'd1,
    EV_PUNCT     = 2'd2
  } ev_kind_t;

  // slot 0: released slash, slot 1: end of word, slot 2: punctuation or word character
  typedef struct packed {
    logic [2:0]      mask;
    logic [CntW-1:0] line;
    logic [CntW-1:0] col0;
    logic [CntW-1:0] col1;
    logic [CntW-1:0] col2;
    ev_kind_t        kind2;
    logic [7:0]      char2;
  } bundle_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == {CntW{1'b1}}) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    case (b) inside
      8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3B,
      8'h2B, 8'h2D, 8'h2A, 8'h26, 8'h2C, 8'h2E, 8'h3A: is_punct = 1'b1;
      default: is_punct = 1'b0;
    endcase
  endfunction

endpackage

### rtl/stt_front.sv
module stt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_flush,
  input  logic [7:0]        in_byte,
  output logic              push_valid,
  output stt_pkg::bundle_t  push_data
);

  logic [stt_pkg::CntW-1:0] line_r, line_nxt;
  logic [stt_pkg::CntW-1:0] col_r, col_nxt;
  logic [stt_pkg::CntW-1:0] slash_col_r, slash_col_nxt;
  logic                     comment_r, comment_nxt;
  logic                     word_r, word_nxt;
  logic                     slash_r, slash_nxt;
  logic [stt_pkg::CntW-1:0] col_inc;
  logic                     accept;
  logic                     is_nl;
  stt_pkg::bundle_t         bnd;

  assign accept  = in_valid & in_ready;
  assign col_inc = stt_pkg::sat_inc(col_r);
  assign is_nl   = (in_byte == stt_pkg::ChNl);

  always_comb begin
    line_nxt      = line_r;
    col_nxt       = col_r;
    slash_col_nxt = slash_col_r;
    comment_nxt   = comment_r;
    word_nxt      = word_r;
    slash_nxt     = slash_r;
    bnd.mask      = 3'b000;
    bnd.line      = line_r;
    bnd.col0      = slash_col_r;
    bnd.col1      = (in_flush | is_nl) ? col_r : col_inc;
    bnd.col2      = col_inc;
    bnd.kind2     = stt_pkg::EV_WORD_CHAR;
    bnd.char2     = in_byte;
    if (in_flush) begin
      bnd.mask[0] = slash_r;
      bnd.mask[1] = word_r;
      slash_nxt   = 1'b0;
      word_nxt    = 1'b0;
    end else if (slash_r && in_byte == stt_pkg::ChSlash) begin
      col_nxt     = col_inc;
      slash_nxt   = 1'b0;
      comment_nxt = 1'b1;
    end else begin
      bnd.mask[0] = slash_r;
      slash_nxt   = 1'b0;
      if (in_byte == stt_pkg::ChNul) begin
        col_nxt = col_r;
      end else if (is_nl) begin
        bnd.mask[1] = word_r;
        word_nxt    = 1'b0;
        comment_nxt = 1'b0;
        line_nxt    = stt_pkg::sat_inc(line_r);
        col_nxt     = '0;
      end else begin
        col_nxt = col_inc;
        if (comment_r) begin
          col_nxt = col_inc;
        end else if (in_byte == stt_pkg::ChSlash) begin
          bnd.mask[1]   = word_r;
          word_nxt      = 1'b0;
          slash_nxt     = 1'b1;
          slash_col_nxt = col_inc;
        end else if (in_byte == stt_pkg::ChSpace || in_byte == stt_pkg::ChTab ||
                     in_byte == stt_pkg::ChCr) begin
          bnd.mask[1] = word_r;
          word_nxt    = 1'b0;
        end else if (stt_pkg::is_punct(in_byte)) begin
          bnd.mask[1] = word_r;
          word_nxt    = 1'b0;
          bnd.mask[2] = 1'b1;
          bnd.kind2   = stt_pkg::EV_PUNCT;
        end else begin
          bnd.mask[2] = 1'b1;
          word_nxt    = 1'b1;
        end
      end
    end
  end

  assign push_valid = accept & (bnd.mask != 3'b000);
  assign push_data  = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= '0;
      col_r       <= '0;
      slash_col_r <= '0;
      comment_r   <= 1'b0;
      word_r      <= 1'b0;
      slash_r     <= 1'b0;
    end else if (accept) begin
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      slash_col_r <= slash_col_nxt;
      comment_r   <= comment_nxt;
      word_r      <= word_nxt;
      slash_r     <= slash_nxt;
    end
  end

endmodule

### rtl/stt_queue.sv
module stt_queue #(
  parameter int unsigned Depth = stt_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  stt_pkg::bundle_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output stt_pkg::bundle_t  pop_data
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  stt_pkg::bundle_t mem_r [Depth];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CW'(Depth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LastIdx) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LastIdx) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

### rtl/stt_back.sv
module stt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  stt_pkg::bundle_t  pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_char,
  output logic [15:0]       out_line,
  output logic [15:0]       out_col,
  output logic              out_last
);

  stt_pkg::bundle_t bnd_r, bnd_nxt;
  logic [2:0]       mask_r, mask_nxt;
  logic [2:0]       rest;
  logic             take;
  logic             load;
  stt_pkg::ev_kind_t kind;

  assign rest      = mask_r & (mask_r - 3'd1);
  assign out_valid = (mask_r != 3'b000);
  assign take      = out_valid & out_ready;
  assign pop_ready = !out_valid || (take && rest == 3'b000);
  assign load      = pop_valid & pop_ready;

  always_comb begin
    kind     = bnd_r.kind2;
    out_char = bnd_r.char2;
    out_col  = bnd_r.col2;
    if (mask_r[0]) begin
      kind     = stt_pkg::EV_PUNCT;
      out_char = stt_pkg::ChSlash;
      out_col  = bnd_r.col0;
    end else if (mask_r[1]) begin
      kind     = stt_pkg::EV_WORD_END;
      out_char = stt_pkg::ChNul;
      out_col  = bnd_r.col1;
    end
  end

  assign out_kind = kind;
  assign out_line = bnd_r.line;
  assign out_last = (rest == 3'b000);

  always_comb begin
    mask_nxt = mask_r;
    bnd_nxt  = bnd_r;
    if (take) begin
      mask_nxt = rest;
    end
    if (load) begin
      mask_nxt = pop_data.mask;
      bnd_nxt  = pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'b000;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bnd_r <= bnd_nxt;
  end

endmodule

### rtl/source_text_tokenizer.sv
// Channel  Direction  tdata                                      tuser            tlast
// in_      slave      [7:0] src_byte                             [0] req_type     -
// out_     master     [7:0] token_char [23:8] line_no [39:24] col_no  [1:0] event_kind  last_of_run
//
// One item is accepted per cycle while the bundle queue has room.
// Each item yields up to two results, sent from the output register one per cycle when not stalled.
// Output rate (one result per cycle when not stalled) bounds throughput when bursts fill the queue.
// Synchronous active-low reset clears counters, flags, queue pointers and output valid mask.
// Input stalls only when the queue is full; the output may stall freely.
module source_text_tokenizer #(
  parameter int unsigned QueueDepth = stt_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] src_byte
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] token_char, [23:8] line_no, [39:24] col_no
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast
);

  logic             push_valid;
  logic             pop_valid;
  logic             pop_ready;
  stt_pkg::bundle_t push_data;
  stt_pkg::bundle_t pop_data;
  logic [7:0]       ch;
  logic [15:0]      line;
  logic [15:0]      col;

  stt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_flush   (in_tuser),
    .in_byte    (in_tdata),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  stt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (in_tready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_char  (ch),
    .out_line  (line),
    .out_col   (col),
    .out_last  (out_tlast)
  );

  assign out_tdata = {col, line, ch};

endmodule
